### hw/rtl/lsht_pkg.sv
// Shared types and constants for the layered shape hit test block.
`default_nettype none

package lsht_pkg;

	localparam int MAX_SHAPES = 64;
	localparam int COORD_BITS = 16;
	localparam int CW         = COORD_BITS;
	localparam int DW         = CW + 1;
	localparam int SQW        = 2 * DW;
	localparam int SUMW       = SQW + 1;
	localparam int RAD_BITS   = 15;
	localparam int RSQW       = 2 * RAD_BITS;
	localparam int COLW       = 8;
	localparam int OPW        = 2;
	localparam int CNTW       = $clog2(MAX_SHAPES + 1);

	localparam logic [COLW-1:0] EMPTY_PIXEL = 8'd46;

	typedef enum logic [OPW-1:0] {
		OP_CIRCLE = 2'd0,
		OP_RECT   = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic                 is_rect;
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic [RAD_BITS-1:0]  radius;
		logic [COLW-1:0]      colour;
	} shape_t;

	typedef struct packed {
		logic                 valid;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [COLW-1:0]      pix;
	} query_t;

endpackage

`default_nettype wire

### hw/rtl/lsht_cell.sv
// One cell of the shape chain: holds one shape and tests passing query words against it.
`default_nettype none

module lsht_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            wr_en,
	input  wire lsht_pkg::shape_t wr_shape,
	input  wire logic            used,
	input  wire lsht_pkg::query_t q_in,
	output lsht_pkg::query_t     q_out,
	output logic                 busy
);

	lsht_pkg::shape_t shape_q;

	logic                           qv_s1;
	logic signed [lsht_pkg::CW-1:0] x_s1;
	logic signed [lsht_pkg::CW-1:0] y_s1;
	logic [lsht_pkg::COLW-1:0]      pix_s1;
	logic [lsht_pkg::SQW-1:0]       dx2_s1;
	logic [lsht_pkg::SQW-1:0]       dy2_s1;
	logic [lsht_pkg::RSQW-1:0]      r2_s1;
	logic                           rhit_s1;

	logic                           qv_s2;
	logic signed [lsht_pkg::CW-1:0] x_s2;
	logic signed [lsht_pkg::CW-1:0] y_s2;
	logic [lsht_pkg::COLW-1:0]      pix_s2;

	logic signed [lsht_pkg::DW-1:0]  dx;
	logic signed [lsht_pkg::DW-1:0]  dy;
	logic signed [lsht_pkg::SQW-1:0] dx2;
	logic signed [lsht_pkg::SQW-1:0] dy2;
	logic                            rhit;
	logic                            chit;
	logic                            hit;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			shape_q <= wr_shape;
		end
	end

	always_comb begin
		dx   = lsht_pkg::DW'(shape_q.x0) - lsht_pkg::DW'(q_in.x);
		dy   = lsht_pkg::DW'(shape_q.y0) - lsht_pkg::DW'(q_in.y);
		dx2  = lsht_pkg::SQW'(dx) * lsht_pkg::SQW'(dx);
		dy2  = lsht_pkg::SQW'(dy) * lsht_pkg::SQW'(dy);
		rhit = (shape_q.x0 <= q_in.x) && (q_in.x <= shape_q.x1) &&
		       (shape_q.y0 <= q_in.y) && (q_in.y <= shape_q.y1);
	end

	// stage 1: squares and box compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s1 <= 1'b0;
		end else if (adv) begin
			qv_s1 <= q_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= q_in.x;
			y_s1    <= q_in.y;
			pix_s1  <= q_in.pix;
			dx2_s1  <= dx2;
			dy2_s1  <= dy2;
			r2_s1   <= lsht_pkg::RSQW'(shape_q.radius) * lsht_pkg::RSQW'(shape_q.radius);
			rhit_s1 <= rhit;
		end
	end

	always_comb begin
		chit = (lsht_pkg::SUMW'(dx2_s1) + lsht_pkg::SUMW'(dy2_s1)) <= lsht_pkg::SUMW'(r2_s1);
		hit  = used && (shape_q.is_rect ? rhit_s1 : chit);
	end

	// stage 2: distance compare, overwrite the pixel on a hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s2 <= 1'b0;
		end else if (adv) begin
			qv_s2 <= qv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			pix_s2 <= hit ? shape_q.colour : pix_s1;
		end
	end

	always_comb begin
		q_out.valid = qv_s2;
		q_out.x     = x_s2;
		q_out.y     = y_s2;
		q_out.pix   = pix_s2;
		busy        = qv_s1 | qv_s2;
	end

endmodule

`default_nettype wire

### hw/rtl/layered_shape_hit_test_top.sv
// Top level of the layered shape hit test: shape table as a chain of cells.
// Usage:
//  Input channel (in_valid/in_ready) takes one word per handshake: opcode 0 adds a
//  circle (ax, ay, radius, colour), opcode 1 adds a rectangle (ax, ay, bx, by,
//  colour), opcode 2 queries point (ax, ay), opcode 3 is taken and ignored.
//  Adds beyond 64 shapes are taken and dropped.
//  Output channel (out_valid/out_ready) gives one pixel word per query: the colour
//  of the newest covering shape, or '.' when none covers.
//  A query walks the row of 64 cells, two register stages per cell, oldest shape
//  first, then lands in the output register. Queries are taken one per cycle
//  back to back while the output is not stalled. An add waits until no query is
//  in the cell row, then writes its cell directly.
//  When the output register holds a word that is not taken, the whole row holds
//  and in_ready drops; no word is lost.
//  Reset clears the shape count and all stage valid bits; cell contents are
//  undefined until written and are masked by the count.
`default_nettype none

module layered_shape_hit_test_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    opcode,
	input  wire logic signed [15:0]            ax,
	input  wire logic signed [15:0]            ay,
	input  wire logic signed [15:0]            bx,
	input  wire logic signed [15:0]            by,
	input  wire logic [14:0]                   radius,
	input  wire logic [7:0]                    colour,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         pixel
);

	localparam int N = lsht_pkg::MAX_SHAPES;

	lsht_pkg::op_t             op;
	lsht_pkg::shape_t          new_shape;
	lsht_pkg::query_t          q [N+1];
	logic [N-1:0]              wr_en;
	logic [N-1:0]              used;
	logic [N-1:0]              cell_busy;
	logic                      adv;
	logic                      busy;
	logic                      is_add;
	logic                      accept;
	logic [lsht_pkg::CNTW-1:0] count_q;
	logic                      out_valid_q;
	logic [lsht_pkg::COLW-1:0] pixel_q;

	always_comb begin
		op       = lsht_pkg::op_t'(opcode);
		adv      = !out_valid_q || out_ready;
		busy     = |cell_busy;
		is_add   = (op == lsht_pkg::OP_CIRCLE) || (op == lsht_pkg::OP_RECT);
		in_ready = adv && (!is_add || !busy);
		accept   = in_valid && in_ready;

		new_shape.is_rect = (op == lsht_pkg::OP_RECT);
		new_shape.x0      = ax[lsht_pkg::CW-1:0];
		new_shape.y0      = ay[lsht_pkg::CW-1:0];
		new_shape.x1      = bx[lsht_pkg::CW-1:0];
		new_shape.y1      = by[lsht_pkg::CW-1:0];
		new_shape.radius  = radius;
		new_shape.colour  = colour;

		q[0].valid = accept && (op == lsht_pkg::OP_QUERY);
		q[0].x     = ax[lsht_pkg::CW-1:0];
		q[0].y     = ay[lsht_pkg::CW-1:0];
		q[0].pix   = lsht_pkg::EMPTY_PIXEL;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign wr_en[i] = accept && is_add && (count_q == lsht_pkg::CNTW'(i));
		assign used[i]  = lsht_pkg::CNTW'(i) < count_q;

		lsht_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.wr_en    (wr_en[i]),
			.wr_shape (new_shape),
			.used     (used[i]),
			.q_in     (q[i]),
			.q_out    (q[i+1]),
			.busy     (cell_busy[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && is_add && (count_q < lsht_pkg::CNTW'(N))) begin
			count_q <= count_q + lsht_pkg::CNTW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= q[N].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_q <= q[N].pix;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel     = pixel_q;

endmodule

`default_nettype wire

### hw/rtl/lsht_checker.sv
// Port-level assertions for the layered shape hit test, bound to the top level.
`default_nettype none

module lsht_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [1:0] opcode,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] pixel
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel))
		else $error("output word changed while stalled");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_add_waits_query: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == lsht_pkg::OP_QUERY)
		|=> !(in_ready && (opcode == lsht_pkg::OP_CIRCLE || opcode == lsht_pkg::OP_RECT)))
		else $error("add taken while a query is in flight");

endmodule

bind layered_shape_hit_test_top lsht_checker u_lsht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.opcode    (opcode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pixel     (pixel)
);

`default_nettype wire
